// File: design/pfe_pkg.sv
`timescale 1ns / 1ps
// Shared types, register codes and helpers for the particle Euler step.
// No dependencies; the top level imports this package.
package pfe_pkg;

  // Register index map of the configuration port
  typedef enum logic [3:0] {
    REG_GRAVITY     = 4'd0,
    REG_MASS        = 4'd1,
    REG_TIME_STEP   = 4'd2,
    REG_INTER_X     = 4'd3,
    REG_INTER_Y     = 4'd4,
    REG_INTER_RAD   = 4'd5,
    REG_INTER_STR   = 4'd6,
    REG_PUSH_SIGN   = 4'd7
  } reg_idx_t;

  // Input item: one particle
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } particle_t;

  // Result item: updated particle
  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic               was_pushed;
  } result_t;

  // Side data that rides along the pipeline next to the long arithmetic units
  typedef struct packed {
    particle_t          p;
    logic signed [31:0] fy;        // gravity force, saturated
    logic               sdx;       // x offset to interaction point is negative
    logic               sdy;
    logic               in_range;  // interaction force applies
    logic [30:0]        mdx;       // |dx|, valid when in_range
    logic [30:0]        mdy;
    logic               dzero;     // distance is zero
    logic [31:0]        smag;      // |strength * falloff|
    logic               sneg;      // sign of the scaled strength term
    logic               ovx;       // velocity change quotient overflows
    logic               ovy;
    logic               fnx;       // force component is negative
    logic               fny;
  } ctx_t;

  // Clamp a wide signed value to 32 signed bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// File: design/particle_force_euler_step.sv
`timescale 1ns / 1ps
// Top level: one explicit Euler step of a 2D particle with an interaction force.
// Depends on pfe_pkg, pfe_isqrt, pfe_div and pfe_delay.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+---------------------------
//   particle  | particle_valid / _stall    | pfe_pkg::particle_t
//   result    | result_valid / _stall      | pfe_pkg::result_t
//   cfg       | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One item per cycle unless result_stall holds the pipeline; Q16.16 at the default FRAC_BITS.
// The latency is set by the 32-stage square root, the FRAC_BITS+1 stage direction
// divider and the 34-stage velocity divider placed in series.
// rst is synchronous, clears the valid bits and resets the configuration registers to their defaults.
// A held result with result_stall high freezes the whole pipeline for that
// cycle and raises particle_stall; nothing is dropped or repeated.
module particle_force_euler_step #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               particle_valid,
  output logic               particle_stall,
  input  pfe_pkg::particle_t particle,
  output logic               result_valid,
  input  logic               result_stall,
  output pfe_pkg::result_t   result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  import pfe_pkg::*;

  localparam int          F    = FRAC_BITS;
  localparam int          LAT  = FRAC_BITS + 80;
  localparam int          PW   = 32 + FRAC_BITS;
  localparam logic [31:0] NEGL = 32'((2**FRAC_BITS + 9999) / 10000);

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic signed [31:0] gravity;
  logic [30:0]        particle_mass;
  logic [30:0]        time_step;
  logic signed [31:0] interaction_x;
  logic signed [31:0] interaction_y;
  logic [30:0]        interaction_radius;
  logic signed [31:0] interaction_strength;
  logic               push_sign;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity              <= '0;
      particle_mass        <= 31'(1 << FRAC_BITS);
      time_step            <= '0;
      interaction_x        <= '0;
      interaction_y        <= '0;
      interaction_radius   <= '0;
      interaction_strength <= '0;
      push_sign            <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRAVITY:   gravity              <= cfg_data;
        REG_MASS:      particle_mass        <= cfg_data[30:0];
        REG_TIME_STEP: time_step            <= cfg_data[30:0];
        REG_INTER_X:   interaction_x        <= cfg_data;
        REG_INTER_Y:   interaction_y        <= cfg_data;
        REG_INTER_RAD: interaction_radius   <= cfg_data[30:0];
        REG_INTER_STR: interaction_strength <= cfg_data;
        REG_PUSH_SIGN: push_sign            <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // derived static settings
  logic [30:0] mass_eff;
  logic [31:0] str_abs;
  logic        str_ok;

  assign mass_eff = (particle_mass == '0) ? 31'd1 : particle_mass;
  assign str_abs  = interaction_strength[31] ? (~interaction_strength + 32'd1)
                                             : interaction_strength;
  assign str_ok   = (str_abs >= NEGL);

  // ---------------------------------------------------------------------------
  // Global advance and valid chain
  logic           en;
  logic [LAT:1]   vld;

  assign particle_stall = result_valid & result_stall;
  assign en             = ~particle_stall;
  assign result_valid   = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:1], particle_valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  particle_t s1_p;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_p <= particle;
    end
  end

  // Stage 2: offsets to the interaction point, box test, gravity times mass
  logic signed [32:0] dx_c, dy_c;
  logic [32:0]        adx_c, ady_c;
  logic signed [63:0] gm_c;
  ctx_t               s2_c_next;
  ctx_t               s2_c;
  logic [31:0]        s2_mdx, s2_mdy;
  logic               s2_box;
  logic signed [62:0] s2_gm;

  always_comb begin
    dx_c  = 33'(interaction_x) - 33'(s1_p.pos_x);
    dy_c  = 33'(interaction_y) - 33'(s1_p.pos_y);
    adx_c = dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
    ady_c = dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
    gm_c  = gravity * $signed({1'b0, mass_eff});
    s2_c_next     = '0;
    s2_c_next.p   = s1_p;
    s2_c_next.sdx = dx_c[32];
    s2_c_next.sdy = dy_c[32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_c        <= s2_c_next;
      s2_mdx      <= adx_c[31:0];
      s2_mdy      <= ady_c[31:0];
      s2_box      <= (adx_c[31:0] < {1'b0, interaction_radius}) &&
                     (ady_c[31:0] < {1'b0, interaction_radius});
      s2_gm       <= gm_c[62:0];
    end
  end

  // Stage 3: squares and the gravity force
  logic [61:0]        sqx_c, sqy_c, rsq_c;
  logic [62:0]        gmag_c, gsh_c;
  logic signed [63:0] gw_c;
  ctx_t               s3_c_next;
  ctx_t               s3_c;
  logic [61:0]        s3_sqx, s3_sqy, s3_rsq;
  logic               s3_box;

  always_comb begin
    sqx_c  = s2_mdx[30:0] * s2_mdx[30:0];
    sqy_c  = s2_mdy[30:0] * s2_mdy[30:0];
    rsq_c  = interaction_radius * interaction_radius;
    gmag_c = s2_gm[62] ? 63'(-s2_gm) : 63'(s2_gm);
    gsh_c  = gmag_c >> F;
    gw_c   = s2_gm[62] ? -$signed(64'(gsh_c)) : $signed(64'(gsh_c));
    s3_c_next     = s2_c;
    s3_c_next.fy  = sat32(gw_c);
    s3_c_next.mdx = s2_mdx[30:0];
    s3_c_next.mdy = s2_mdy[30:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_c     <= s3_c_next;
      s3_sqx   <= sqx_c;
      s3_sqy   <= sqy_c;
      s3_rsq   <= rsq_c;
      s3_box   <= s2_box;
    end
  end

  // Stage 4: squared distance
  ctx_t        s4_c;
  logic [62:0] s4_dsq;
  logic [61:0] s4_rsq;
  logic        s4_box;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_c   <= s3_c;
      s4_dsq <= 63'(s3_sqx) + 63'(s3_sqy);
      s4_rsq <= s3_rsq;
      s4_box <= s3_box;
    end
  end

  // Stage 5: in-range test and falloff numerator
  ctx_t        s5_c_next;
  ctx_t        s5_c;
  logic [62:0] s5_dsq;
  logic [61:0] s5_rsq;
  logic [61:0] s5_rem;

  always_comb begin
    s5_c_next          = s4_c;
    s5_c_next.in_range = s4_box && str_ok && (s4_dsq < 63'(s4_rsq));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_c        <= s5_c_next;
      s5_dsq      <= s4_dsq;
      s5_rsq      <= s4_rsq;
      s5_rem      <= s4_rsq - s4_dsq[61:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Distance root and falloff fraction run side by side
  logic [31:0]  s37_root;
  logic [F-1:0] fall_q, fall37;
  ctx_t         c37;

  pfe_isqrt #(.IW(64)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .x    (64'(s5_dsq)),
    .root (s37_root)
  );

  pfe_div #(.DW(62), .QB(F)) u_fall (
    .clk  (clk),
    .en   (en),
    .den  (s5_rsq),
    .rem0 (s5_rem),
    .num  ('0),
    .quo  (fall_q)
  );

  pfe_delay #(.W(F), .DEPTH(32 - F)) u_fall_dly (
    .clk  (clk),
    .en   (en),
    .din  (fall_q),
    .dout (fall37)
  );

  pfe_delay #(.W($bits(ctx_t)), .DEPTH(32)) u_ctx_a (
    .clk  (clk),
    .en   (en),
    .din  (s5_c),
    .dout (c37)
  );

  // ---------------------------------------------------------------------------
  // Unit direction: |d| * 2^F / dist, one bit per stage
  logic [F:0] quo_x, quo_y;

  pfe_div #(.DW(32), .QB(F + 1)) u_dir_x (
    .clk  (clk),
    .en   (en),
    .den  (s37_root),
    .rem0 ({2'b00, c37.mdx[30:1]}),
    .num  ({c37.mdx[0], F'(0)}),
    .quo  (quo_x)
  );

  pfe_div #(.DW(32), .QB(F + 1)) u_dir_y (
    .clk  (clk),
    .en   (en),
    .den  (s37_root),
    .rem0 ({2'b00, c37.mdy[30:1]}),
    .num  ({c37.mdy[0], F'(0)}),
    .quo  (quo_y)
  );

  // Strength times falloff while the direction divides
  ctx_t          c38_next, c39_next;
  ctx_t          c38, c39, cd;
  logic [PW-1:0] prod38;

  always_comb begin
    c38_next       = c37;
    c38_next.dzero = (s37_root == '0);
    c39_next       = c38;
    c39_next.smag  = 32'(prod38 >> F);
    c39_next.sneg  = interaction_strength[31] ^ ~push_sign;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c38       <= c38_next;
      prod38    <= PW'(str_abs) * PW'(fall37);
      c39       <= c39_next;
    end
  end

  pfe_delay #(.W($bits(ctx_t)), .DEPTH(F - 1)) u_ctx_b (
    .clk  (clk),
    .en   (en),
    .din  (c39),
    .dout (cd)
  );

  // ---------------------------------------------------------------------------
  // M1: direction times scaled strength and times half the gravity force
  logic [F:0]    uxm_c, uym_c;
  logic [31:0]   half_c;
  ctx_t          m1_c;
  logic [F+32:0] m1_p1x, m1_p2x, m1_p1y, m1_p2y;

  always_comb begin
    uxm_c  = cd.dzero ? '0 : quo_x;
    uym_c  = cd.dzero ? '0 : quo_y;
    half_c = cd.fy[31] ? 32'(-cd.fy) : 32'(cd.fy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_c   <= cd;
      m1_p1x <= (F+33)'(uxm_c) * (F+33)'(cd.smag);
      m1_p2x <= (F+33)'(uxm_c) * (F+33)'(half_c);
      m1_p1y <= (F+33)'(uym_c) * (F+33)'(cd.smag);
      m1_p2y <= (F+33)'(uym_c) * (F+33)'(half_c);
    end
  end

  // M2: rescale, apply signs, sum the force terms
  logic [31:0]        h1x_c, h2x_c, h1y_c, h2y_c;
  logic signed [33:0] t1x_c, t2x_c, t1y_c, t2y_c;
  ctx_t               m2_c;
  logic signed [35:0] m2_fx, m2_fy;

  always_comb begin
    h1x_c = 32'(m1_p1x >> F);
    h2x_c = 32'(m1_p2x >> (F + 1));
    h1y_c = 32'(m1_p1y >> F);
    h2y_c = 32'(m1_p2y >> (F + 1));
    t1x_c = (m1_c.sdx ^ m1_c.sneg) ? -$signed({2'b00, h1x_c}) : $signed({2'b00, h1x_c});
    t2x_c = (m1_c.sdx ^ ~push_sign) ? -$signed({2'b00, h2x_c}) : $signed({2'b00, h2x_c});
    t1y_c = (m1_c.sdy ^ m1_c.sneg) ? -$signed({2'b00, h1y_c}) : $signed({2'b00, h1y_c});
    t2y_c = (m1_c.sdy ^ ~push_sign) ? -$signed({2'b00, h2y_c}) : $signed({2'b00, h2y_c});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_c  <= m1_c;
      m2_fx <= 36'(t1x_c) + 36'(t2x_c);
      m2_fy <= 36'(m1_c.fy) + 36'(t1y_c) + 36'(t2y_c);
    end
  end

  // M3: saturate and pick the force of a pushed or free particle
  ctx_t               m3_c;
  logic signed [31:0] m3_fx, m3_fy;

  always_ff @(posedge clk) begin
    if (en) begin
      m3_c  <= m2_c;
      m3_fx <= m2_c.in_range ? sat32(64'(m2_fx)) : 32'sd0;
      m3_fy <= m2_c.in_range ? sat32(64'(m2_fy)) : m2_c.fy;
    end
  end

  // M4: time step times force magnitude
  logic [31:0] fxa_c, fya_c;
  ctx_t        m4_c_next;
  ctx_t        m4_c;
  logic [61:0] m4_nx, m4_ny;

  always_comb begin
    fxa_c = m3_fx[31] ? 32'(-m3_fx) : 32'(m3_fx);
    fya_c = m3_fy[31] ? 32'(-m3_fy) : 32'(m3_fy);
    m4_c_next     = m3_c;
    m4_c_next.fnx = m3_fx[31];
    m4_c_next.fny = m3_fy[31];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m4_c     <= m4_c_next;
      m4_nx    <= 62'(time_step) * 62'(fxa_c);
      m4_ny    <= 62'(time_step) * 62'(fya_c);
    end
  end

  // M5: overflow check ahead of the 34-bit quotient
  ctx_t        m5_c_next;
  ctx_t        m5_c;
  logic [30:0] m5_remx, m5_remy;
  logic [33:0] m5_numx, m5_numy;

  always_comb begin
    m5_c_next     = m4_c;
    m5_c_next.ovx = (31'(m4_nx[61:34]) >= mass_eff);
    m5_c_next.ovy = (31'(m4_ny[61:34]) >= mass_eff);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m5_c     <= m5_c_next;
      m5_remx  <= 31'(m4_nx[61:34]);
      m5_remy  <= 31'(m4_ny[61:34]);
      m5_numx  <= m4_nx[33:0];
      m5_numy  <= m4_ny[33:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Velocity change: divide by mass
  logic [33:0] dvq_x, dvq_y;
  ctx_t        cv;

  pfe_div #(.DW(31), .QB(34)) u_vel_x (
    .clk  (clk),
    .en   (en),
    .den  (mass_eff),
    .rem0 (m5_remx),
    .num  (m5_numx),
    .quo  (dvq_x)
  );

  pfe_div #(.DW(31), .QB(34)) u_vel_y (
    .clk  (clk),
    .en   (en),
    .den  (mass_eff),
    .rem0 (m5_remy),
    .num  (m5_numy),
    .quo  (dvq_y)
  );

  pfe_delay #(.W($bits(ctx_t)), .DEPTH(34)) u_ctx_c (
    .clk  (clk),
    .en   (en),
    .din  (m5_c),
    .dout (cv)
  );

  // V: new velocity
  logic [33:0]        qx_c, qy_c;
  logic signed [35:0] dvx_c, dvy_c;
  logic signed [36:0] svx_c, svy_c;
  ctx_t               v_c;
  logic signed [31:0] v_nvx, v_nvy;

  always_comb begin
    qx_c  = cv.ovx ? '1 : dvq_x;
    qy_c  = cv.ovy ? '1 : dvq_y;
    dvx_c = cv.fnx ? -$signed({2'b00, qx_c}) : $signed({2'b00, qx_c});
    dvy_c = cv.fny ? -$signed({2'b00, qy_c}) : $signed({2'b00, qy_c});
    svx_c = 37'(cv.p.vel_x) + 37'(dvx_c);
    svy_c = 37'(cv.p.vel_y) + 37'(dvy_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_c   <= cv;
      v_nvx <= sat32(64'(svx_c));
      v_nvy <= sat32(64'(svy_c));
    end
  end

  // P1: time step times new velocity
  logic [31:0]        nxa_c, nya_c;
  ctx_t               p1_c;
  logic [61:0]        p1_mx, p1_my;
  logic               p1_negx, p1_negy;
  logic signed [31:0] p1_nvx, p1_nvy;

  always_comb begin
    nxa_c = v_nvx[31] ? 32'(-v_nvx) : 32'(v_nvx);
    nya_c = v_nvy[31] ? 32'(-v_nvy) : 32'(v_nvy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_c    <= v_c;
      p1_mx   <= 62'(time_step) * 62'(nxa_c);
      p1_my   <= 62'(time_step) * 62'(nya_c);
      p1_negx <= v_nvx[31];
      p1_negy <= v_nvy[31];
      p1_nvx  <= v_nvx;
      p1_nvy  <= v_nvy;
    end
  end

  // P2: new position into the output register
  logic [61:0]        shx_c, shy_c;
  logic signed [62:0] dpx_c, dpy_c;
  logic signed [63:0] spx_c, spy_c;
  result_t            result_next;

  always_comb begin
    shx_c = p1_mx >> F;
    shy_c = p1_my >> F;
    dpx_c = p1_negx ? -$signed({1'b0, shx_c}) : $signed({1'b0, shx_c});
    dpy_c = p1_negy ? -$signed({1'b0, shy_c}) : $signed({1'b0, shy_c});
    spx_c = 64'(p1_c.p.pos_x) + 64'(dpx_c);
    spy_c = 64'(p1_c.p.pos_y) + 64'(dpy_c);
    result_next.new_pos_x  = sat32(spx_c);
    result_next.new_pos_y  = sat32(spy_c);
    result_next.new_vel_x  = p1_nvx;
    result_next.new_vel_y  = p1_nvy;
    result_next.was_pushed = p1_c.in_range;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= result_next;
    end
  end

endmodule

// File: design/pfe_delay.sv
`timescale 1ns / 1ps
// Enable-gated delay line that keeps side data aligned with the long units.
// Depends on nothing.
module pfe_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sr [DEPTH];

  // shift one place per advancing cycle
  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign dout = sr[DEPTH-1];

endmodule

// File: design/pfe_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on nothing. Requires rem0 < den for an exact quotient.
module pfe_div #(
  parameter int DW = 32,
  parameter int QB = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] den,
  input  logic [DW-1:0] rem0,
  input  logic [QB-1:0] num,
  output logic [QB-1:0] quo
);

  logic [DW-1:0] rem_s [QB];
  logic [DW-1:0] den_s [QB];
  logic [QB-1:0] num_s [QB];
  logic [QB-1:0] quo_s [QB];

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [DW-1:0] rem_p;
    logic [DW-1:0] den_p;
    logic [QB-1:0] num_p;
    logic [QB-1:0] quo_p;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_p = rem0;
      assign den_p = den;
      assign num_p = num;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = rem_s[k-1];
      assign den_p = den_s[k-1];
      assign num_p = num_s[k-1];
      assign quo_p = quo_s[k-1];
    end

    // bring down the next numerator bit and try the subtract
    always_comb begin
      trial = {rem_p, num_p[QB-1]};
      ge    = (trial >= {1'b0, den_p});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k] <= ge ? DW'(trial - {1'b0, den_p}) : trial[DW-1:0];
        den_s[k] <= den_p;
        num_s[k] <= num_p << 1;
        quo_s[k] <= {quo_p[QB-2:0], ge};
      end
    end
  end

  assign quo = quo_s[QB-1];

endmodule

// File: design/pfe_isqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root (floor), one root bit per register stage.
// Depends on nothing.
module pfe_isqrt #(
  parameter int IW = 64
) (
  input  logic            clk,
  input  logic            en,
  input  logic [IW-1:0]   x,
  output logic [IW/2-1:0] root
);

  localparam int RW = IW / 2;

  logic [IW-1:0] x_s   [RW];
  logic [RW-1:0] q_s   [RW];
  logic [RW+1:0] rem_s [RW];

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [IW-1:0] x_p;
    logic [RW-1:0] q_p;
    logic [RW+1:0] rem_p;
    logic [RW+3:0] r;
    logic [RW+3:0] t;
    logic          ge;

    if (k == 0) begin : g_first
      assign x_p   = x;
      assign q_p   = '0;
      assign rem_p = '0;
    end else begin : g_next
      assign x_p   = x_s[k-1];
      assign q_p   = q_s[k-1];
      assign rem_p = rem_s[k-1];
    end

    // take the next two radicand bits, trial subtract 4q+1
    always_comb begin
      r  = {rem_p, x_p[IW-1:IW-2]};
      t  = {2'b00, q_p, 2'b01};
      ge = (r >= t);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_s[k]   <= x_p << 2;
        q_s[k]   <= {q_p[RW-2:0], ge};
        rem_s[k] <= ge ? (RW+2)'(r - t) : r[RW+1:0];
      end
    end
  end

  assign root = q_s[RW-1];

endmodule
